// ===== hdl/sound_adpcm_block_decoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// sound_adpcm_block_decoder_core_defines.svh
// Assertion macros used by the checker file of the ADPCM block decoder.
// ----------------------------------------------------------------------------
`ifndef SOUND_ADPCM_BLOCK_DECODER_CORE_DEFINES_SVH
`define SOUND_ADPCM_BLOCK_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SABD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sabd assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SABD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sabd assertion failed");

`endif

// ===== hdl/sabd_pkg.sv =====
// ----------------------------------------------------------------------------
// sabd_pkg
// Types, constants and coefficient tables of the ADPCM block decoder.
// ----------------------------------------------------------------------------
package sabd_pkg;

	// Block layout
	localparam logic [3:0] POS_HEADER    = 4'd0;
	localparam logic [3:0] POS_FLAGS     = 4'd1;
	localparam logic [3:0] POS_BLOCK_END = 4'd15;

	// Shift and filter limits
	localparam logic [3:0] SHIFT_BASE = 4'd12;
	localparam logic [2:0] FILTER_MAX = 3'd4;

	// Loop flag bits of byte 1
	localparam int LOOP_END_BIT    = 0;
	localparam int LOOP_REPEAT_BIT = 1;

	// End action codes
	typedef enum logic [1:0] {
		END_CONTINUE = 2'd0,
		END_LOOP     = 2'd1,
		END_STOP     = 2'd2
	} end_action_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_hdr0;   // byte 0: shift and filter
		logic load_hdr1;   // byte 1: loop flags
		logic load_byte;   // any accepted byte; a data byte holds two nibbles
		logic clear_hist;  // restart: clear predictor history
		logic mul_en;      // capture products and scaled nibble
		logic acc_en;      // finish sample, update history and output
		logic sel_hi;      // work on the high nibble
		logic last;        // current byte is the last of the block
	} sabd_cmd_t;

	// First predictor coefficient, scaled by 64
	function automatic logic signed [7:0] coef_a(input logic [2:0] filt);
		logic signed [7:0] k;
		case (filt)
			3'd1:    k = 8'sd60;
			3'd2:    k = 8'sd115;
			3'd3:    k = 8'sd98;
			3'd4:    k = 8'sd122;
			default: k = 8'sd0;
		endcase
		return k;
	endfunction

	// Second predictor coefficient, scaled by 64
	function automatic logic signed [7:0] coef_b(input logic [2:0] filt);
		logic signed [7:0] k;
		case (filt)
			3'd2:    k = -8'sd52;
			3'd3:    k = -8'sd55;
			3'd4:    k = -8'sd60;
			default: k = 8'sd0;
		endcase
		return k;
	endfunction

endpackage

// ===== hdl/sabd_datapath.sv =====
// ----------------------------------------------------------------------------
// sabd_datapath
// Header registers, predictor history, two-stage sample arithmetic and the
// output word register.
// ----------------------------------------------------------------------------
module sabd_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          s_tdata,   // [7:0] data_byte
	input  sabd_pkg::sabd_cmd_t cmd,
	output logic [15:0]         m_tdata,   // [15:0] sample
	output logic                m_tlast,   // block_last
	output logic [2:0]          m_tuser    // [0] pair_last, [2:1] end_action
);
	import sabd_pkg::*;

	logic [7:0]         byte_q;
	logic [3:0]         shift_q;
	logic [2:0]         filt_q;
	logic [1:0]         loop_q;
	logic signed [15:0] h1_q;
	logic signed [15:0] h2_q;

	logic signed [23:0] prod_a_s1;
	logic signed [23:0] prod_b_s1;
	logic signed [15:0] scaled_s1;

	logic [15:0] sample_q;
	logic        pair_last_q;
	logic        block_last_q;
	logic [1:0]  end_action_q;

	logic [3:0]         nib;
	logic [3:0]         sh;
	logic signed [15:0] nib_ext;
	logic signed [23:0] prod_a;
	logic signed [23:0] prod_b;
	logic signed [24:0] psum;
	logic signed [24:0] psum_adj;
	logic signed [24:0] pred;
	logic signed [25:0] raw;
	logic [15:0]        clamped;
	logic [2:0]         hdr_filt;
	logic [1:0]         action;

	// Stage 1: nibble scaling and predictor products
	always_comb begin
		nib     = cmd.sel_hi ? byte_q[7:4] : byte_q[3:0];
		sh      = (shift_q > SHIFT_BASE) ? 4'd0 : SHIFT_BASE - shift_q;
		nib_ext = {{12{nib[3]}}, nib};
		prod_a  = coef_a(filt_q) * h1_q;
		prod_b  = coef_b(filt_q) * h2_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_a_s1 <= prod_a;
			prod_b_s1 <= prod_b;
			scaled_s1 <= nib_ext <<< sh;
		end
	end

	// Stage 2: divide by 64 toward zero, add, saturate
	always_comb begin
		psum     = {prod_a_s1[23], prod_a_s1} + {prod_b_s1[23], prod_b_s1};
		psum_adj = psum + (psum[24] ? 25'sd63 : 25'sd0);
		pred     = psum_adj >>> 6;
		raw      = {{10{scaled_s1[15]}}, scaled_s1} + {pred[24], pred};
		if (raw > 26'sd32767) begin
			clamped = 16'h7FFF;
		end else if (raw < -26'sd32768) begin
			clamped = 16'h8000;
		end else begin
			clamped = raw[15:0];
		end
	end

	// End action of the block, from the loop flags
	always_comb begin
		action = END_CONTINUE;
		if (cmd.last && loop_q[LOOP_END_BIT]) begin
			action = loop_q[LOOP_REPEAT_BIT] ? END_LOOP : END_STOP;
		end
	end

	assign hdr_filt = (s_tdata[6:4] > FILTER_MAX) ? FILTER_MAX : s_tdata[6:4];

	// Header and history state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			filt_q  <= '0;
			loop_q  <= '0;
			h1_q    <= '0;
			h2_q    <= '0;
		end else begin
			if (cmd.load_hdr0) begin
				shift_q <= s_tdata[3:0];
				filt_q  <= hdr_filt;
			end
			if (cmd.load_hdr1) begin
				loop_q <= s_tdata[1:0];
			end
			if (cmd.clear_hist) begin
				h1_q <= '0;
				h2_q <= '0;
			end else if (cmd.acc_en) begin
				h2_q <= h1_q;
				h1_q <= signed'(clamped);
			end
		end
	end

	// Data byte and output word
	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			byte_q <= s_tdata;
		end
		if (cmd.acc_en) begin
			sample_q     <= clamped;
			pair_last_q  <= cmd.sel_hi;
			block_last_q <= cmd.sel_hi & cmd.last;
			end_action_q <= cmd.sel_hi ? action : END_CONTINUE;
		end
	end

	assign m_tdata = sample_q;
	assign m_tlast = block_last_q;
	assign m_tuser = {end_action_q, pair_last_q};

endmodule

// ===== hdl/sabd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sabd_ctrl
// Controller: byte position, per-nibble sequencing and output word valid.
// ----------------------------------------------------------------------------
module sabd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                s_tuser,   // [0] restart
	output logic                m_tvalid,
	input  logic                m_tready,
	output sabd_pkg::sabd_cmd_t cmd
);
	import sabd_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MUL_LO = 5'b00010,
		ST_ACC_LO = 5'b00100,
		ST_MUL_HI = 5'b01000,
		ST_ACC_HI = 5'b10000
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic [3:0] pos_q;
	logic       last_q;
	logic       m_tvalid_q;

	logic       accept;
	logic [3:0] pos_eff;
	logic       out_free;
	logic       in_acc;
	logic       write;

	assign accept   = s_tvalid & s_tready;
	assign pos_eff  = s_tuser ? POS_HEADER : pos_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign in_acc   = (state_q == ST_ACC_LO) || (state_q == ST_ACC_HI);
	assign write    = in_acc && out_free;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (pos_eff != POS_HEADER) && (pos_eff != POS_FLAGS)) begin
					state_d = ST_MUL_LO;
				end
			end
			ST_MUL_LO: state_d = ST_ACC_LO;
			ST_ACC_LO: begin
				if (out_free) state_d = ST_MUL_HI;
			end
			ST_MUL_HI: state_d = ST_ACC_HI;
			ST_ACC_HI: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd            = '0;
		cmd.load_hdr0  = accept && (pos_eff == POS_HEADER);
		cmd.load_hdr1  = accept && (pos_eff == POS_FLAGS);
		cmd.load_byte  = accept;
		cmd.clear_hist = accept && s_tuser;
		cmd.mul_en     = (state_q == ST_MUL_LO) || (state_q == ST_MUL_HI);
		cmd.acc_en     = write;
		cmd.sel_hi     = (state_q == ST_MUL_HI) || (state_q == ST_ACC_HI);
		cmd.last       = last_q;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= POS_HEADER;
			last_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pos_q  <= pos_eff + 4'd1;
				last_q <= (pos_eff == POS_BLOCK_END);
			end
			if (write) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

endmodule

// ===== hdl/sound_adpcm_block_decoder_core.sv =====
// Each sample of a data byte passes the byte, stage-1 and output registers
// (two-stage multiply/accumulate). Header bytes are taken in idle; a data
// byte runs multiply and accumulate for its low, then its high nibble before
// the next byte is taken, each sample waiting at accumulate while the output
// is held. Reset (arst_n low) clears position, header, history, valid at once.
// ----------------------------------------------------------------------------
// sound_adpcm_block_decoder_core
// Top level of the ADPCM block decoder: 16-byte blocks in, PCM samples out.
// ----------------------------------------------------------------------------
module sound_adpcm_block_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] sample
	output logic        m_tlast,   // block_last
	output logic [2:0]  m_tuser    // [0] pair_last, [2:1] end_action
);
	import sabd_pkg::*;

	sabd_cmd_t cmd;

	// Sequencer
	sabd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Arithmetic and state
	sabd_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.cmd     (cmd),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule

// ===== hdl/sabd_checker.sv =====
// ----------------------------------------------------------------------------
// sabd_checker
// Port-level checks on the output channel of the ADPCM block decoder.
// ----------------------------------------------------------------------------
`include "sound_adpcm_block_decoder_core_defines.svh"

module sabd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,   // [15:0] sample
	input logic        m_tlast,   // block_last
	input logic [2:0]  m_tuser    // [0] pair_last, [2:1] end_action
);
	import sabd_pkg::*;

	// Stalled word holds
	`SABD_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// Block end falls on the second sample of a byte
	`SABD_ASSERT_SAME(a_last_pair, clk, arst_n, m_tvalid && m_tlast, m_tuser[0])

	// End action only at block end
	`SABD_ASSERT_SAME(a_action_last, clk, arst_n, m_tvalid && !m_tlast, m_tuser[2:1] == END_CONTINUE)

	// End action is a defined code
	`SABD_ASSERT_SAME(a_action_code, clk, arst_n, m_tvalid, m_tuser[2:1] == END_CONTINUE || m_tuser[2:1] == END_LOOP || m_tuser[2:1] == END_STOP)

endmodule

bind sound_adpcm_block_decoder_core sabd_checker u_sabd_checker (.*);
